FILE: hw/rtl/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types, constants and the seed prime table for the Bloom filter block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF  = 8;

    localparam int KEY_W   = 8;
    localparam int FUNC_W  = 2;
    localparam int HCNT_W  = 4;
    localparam int HASH_W  = 32;
    localparam int SEED_W  = 6;
    localparam int ROW_W   = 32;
    localparam int COL_W   = 5;
    localparam int MASKED_W = 31;

    localparam logic [HASH_W-1:0] MULT_START = 32'd63689;
    localparam logic [HCNT_W-1:0] HCNT_RESET = 4'd4;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_QUERY  = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;
    localparam func_t FUNC_NONE   = 2'd3;

    // Seed of each hash function: the first sixteen primes.
    function automatic logic [SEED_W-1:0] seed_prime(input logic [3:0] idx);
        logic [SEED_W-1:0] p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            4'd12:   p = 6'd41;
            4'd13:   p = 6'd43;
            4'd14:   p = 6'd47;
            default: p = 6'd53;
        endcase
        return p;
    endfunction

endpackage

FILE: hw/rtl/bfiq_ram.sv
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfiq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter over byte-streamed keys with seeded RS hashes.
// ----------------------------------------------------------------------------
// A key enters one byte per request on the slave stream, tlast on its final
// byte, tuser giving the operation (insert, query, clear; code three is
// dropped silently). Each byte is folded into MAX_HASHES running hashes by a
// single shared 32x32 multiplier: two products per hash, and the block takes
// no new byte until all are done. On the final byte, hash_count probes
// follow. Each probe reduces the 31-bit hash modulo FILTER_BITS on the same
// multiplier: a multiply by the reciprocal 2^32/FILTER_BITS gives a quotient
// that is exact or one short, a multiply back and subtract gives a remainder
// below twice the modulus, and one compare and subtract finishes it. The
// probe then reads, and for insert rewrites, one 32-bit row of the bit array
// RAM. A probe steps through PSTART, REM, FIX, READ and CHECK; after the last
// probe, the result goes to the output register once that register is free.
// A clear request, and reset, sweep the bit array one row per cycle over
// all ceil(FILTER_BITS/32) rows (a clear then reports its result) before the
// block takes the next request.
// Insert, query and clear each return one result (tuser = operation,
// tdata bit 0 = present for a query); non-final key bytes return nothing.
// A finished result waits in the output register while the next key byte is
// taken. Write hash_count via cfg_wr_en/cfg_wr_data only while idle; the
// block does not enforce it. Zero acts as 1, above MAX_HASHES as MAX_HASHES.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int FILTER_BITS = FILTER_BITS_DEF,
    parameter int MAX_HASHES  = MAX_HASHES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    // Slave stream: one key byte per request
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [KEY_W-1:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic [FUNC_W-1:0] s_axis_tuser,   // [1:0] func
    input  logic              s_axis_tlast,   // last_byte

    // Master stream: one result per finished operation
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] present, [7:1] zero
    output logic [FUNC_W-1:0] m_axis_tuser,   // [1:0] op_kind

    // Configuration: hash_count
    input  logic              cfg_wr_en,
    input  logic [HCNT_W-1:0] cfg_wr_data
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int HIDX_W   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int STEP_W   = $clog2(2 * MAX_HASHES + 1);
    localparam int IDX_BITS = $clog2(FILTER_BITS);
    localparam int ROWS     = (FILTER_BITS + ROW_W - 1) / ROW_W;
    localparam int ADDR_W   = IDX_BITS - COL_W;

    localparam logic [STEP_W-1:0]   STEP_END  = STEP_W'(2 * MAX_HASHES);
    localparam logic [ADDR_W-1:0]   ROW_LAST  = ADDR_W'(ROWS - 1);
    localparam logic [HASH_W-1:0]   MOD_WORD  = HASH_W'(FILTER_BITS);
    localparam logic [HASH_W-1:0]   RECIP     =
        HASH_W'(64'h1_0000_0000 / 64'(FILTER_BITS));
    localparam logic [HIDX_W-1:0]   HIDX_LAST = HIDX_W'(MAX_HASHES - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ABSORB = 4'd1;
    localparam logic [3:0] S_PSTART = 4'd2;
    localparam logic [3:0] S_REM    = 4'd3;
    localparam logic [3:0] S_READ   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_DONE   = 4'd6;
    localparam logic [3:0] S_CLEAR  = 4'd7;
    localparam logic [3:0] S_FIX    = 4'd8;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]          state_reg;
    logic [HCNT_W-1:0]   hcnt_reg;

    logic [HASH_W-1:0]   hash_reg [MAX_HASHES];
    logic [HASH_W-1:0]   mult_reg [MAX_HASHES];

    logic [KEY_W-1:0]    byte_reg;
    func_t               func_reg;
    logic                last_reg;

    logic [STEP_W-1:0]   step_reg;
    logic [HASH_W-1:0]   prod_reg;
    logic                wb_valid_reg;
    logic                wb_phase_reg;
    logic [HIDX_W-1:0]   wb_idx_reg;

    logic [HIDX_W-1:0]   pidx_reg;
    logic [MASKED_W-1:0] div_reg;
    logic [HASH_W-1:0]   quo_reg;
    logic [HASH_W-1:0]   diff_reg;
    logic [IDX_BITS-1:0] rem_reg;
    logic                all_set_reg;

    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                clr_report_reg;

    logic                m_valid_reg;
    func_t               m_op_reg;
    logic                m_present_reg;

    // ------------------------------------------------------------------
    // Shared multiplier operands: even steps hash*mult, odd steps
    // mult*seed; during a probe, hash*reciprocal, then quotient*modulus
    // ------------------------------------------------------------------
    logic [HIDX_W-1:0]   step_hidx;
    logic                step_phase;
    logic [HASH_W-1:0]   mul_a;
    logic [HASH_W-1:0]   mul_b;
    logic [2*HASH_W-1:0] mul_p;

    assign step_hidx  = HIDX_W'(step_reg >> 1);
    assign step_phase = step_reg[0];

    always_comb begin
        case (state_reg)
            S_PSTART: begin
                mul_a = {{(HASH_W - MASKED_W){1'b0}}, hash_reg[pidx_reg][MASKED_W-1:0]};
                mul_b = RECIP;
            end
            S_REM: begin
                mul_a = quo_reg;
                mul_b = MOD_WORD;
            end
            default: begin
                if (step_phase) begin
                    mul_a = mult_reg[step_hidx];
                    mul_b = {{(HASH_W - SEED_W){1'b0}}, seed_prime(4'(step_hidx))};
                end else begin
                    mul_a = hash_reg[step_hidx];
                    mul_b = mult_reg[step_hidx];
                end
            end
        endcase
    end

    // Full product; the hash steps keep only the low 32 bits (mod 2^32)
    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Active hash count, clamped to 1..MAX_HASHES, as the last probe index
    // ------------------------------------------------------------------
    logic [HIDX_W-1:0] probe_last;

    always_comb begin
        if (hcnt_reg == '0) begin
            probe_last = '0;
        end else if (5'(hcnt_reg) >= 5'(MAX_HASHES)) begin
            probe_last = HIDX_LAST;
        end else begin
            probe_last = HIDX_W'(hcnt_reg - 4'd1);
        end
    end

    // ------------------------------------------------------------------
    // Bit array RAM, 32 bits per row
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ROW_W-1:0]    ram_rdata;
    logic [COL_W-1:0]    probe_col;
    logic                probe_bit;

    assign ram_raddr = rem_reg[IDX_BITS-1:COL_W];
    assign probe_col = rem_reg[COL_W-1:0];
    assign probe_bit = ram_rdata[probe_col];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ram_raddr;
        ram_wdata = ram_rdata | (ROW_W'(1) << probe_col);
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            S_CHECK: begin
                ram_we = (func_reg == FUNC_INSERT);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bfiq_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (ROWS),
        .ADDR_W (ADDR_W)
    ) u_bits (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_op_reg;
    assign m_axis_tdata  = {7'd0, m_present_reg};

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hcnt_reg <= HCNT_RESET;
        end else if (cfg_wr_en) begin
            hcnt_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            wb_valid_reg   <= 1'b0;
            step_reg       <= '0;
            pidx_reg       <= '0;
            all_set_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
            m_op_reg       <= FUNC_INSERT;
            m_present_reg  <= 1'b0;
            for (int i = 0; i < MAX_HASHES; i++) begin
                hash_reg[i] <= '0;
                mult_reg[i] <= MULT_START;
            end
        end else begin
            // Drop the held result once the consumer takes it, unless a new
            // one replaces it at this edge
            if (m_valid_reg && m_axis_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            // Write back the product registered in the previous cycle
            if (wb_valid_reg) begin
                if (wb_phase_reg) begin
                    mult_reg[wb_idx_reg] <= prod_reg;
                end else begin
                    hash_reg[wb_idx_reg] <= prod_reg + {{(HASH_W - KEY_W){1'b0}}, byte_reg};
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        byte_reg <= s_axis_tdata;
                        func_reg <= s_axis_tuser;
                        last_reg <= s_axis_tlast;
                        if (s_axis_tuser == FUNC_CLEAR) begin
                            // Discard any partial key and sweep the array
                            for (int i = 0; i < MAX_HASHES; i++) begin
                                hash_reg[i] <= '0;
                                mult_reg[i] <= MULT_START;
                            end
                            clr_addr_reg   <= '0;
                            clr_report_reg <= 1'b1;
                            state_reg      <= S_CLEAR;
                        end else if (s_axis_tuser != FUNC_NONE) begin
                            step_reg     <= '0;
                            wb_valid_reg <= 1'b0;
                            state_reg    <= S_ABSORB;
                        end
                    end
                end

                S_ABSORB: begin
                    if (step_reg != STEP_END) begin
                        prod_reg     <= mul_p[HASH_W-1:0];
                        wb_valid_reg <= 1'b1;
                        wb_phase_reg <= step_phase;
                        wb_idx_reg   <= step_hidx;
                        step_reg     <= step_reg + 1'b1;
                    end else begin
                        wb_valid_reg <= 1'b0;
                        if (last_reg) begin
                            pidx_reg    <= '0;
                            all_set_reg <= 1'b1;
                            state_reg   <= S_PSTART;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_PSTART: begin
                    // Mask to 31 bits; the high product word is the quotient
                    div_reg   <= hash_reg[pidx_reg][MASKED_W-1:0];
                    quo_reg   <= mul_p[2*HASH_W-1:HASH_W];
                    state_reg <= S_REM;
                end

                S_REM: begin
                    // Remainder before correction, below twice the modulus
                    diff_reg  <= {{(HASH_W - MASKED_W){1'b0}}, div_reg} - mul_p[HASH_W-1:0];
                    state_reg <= S_FIX;
                end

                S_FIX: begin
                    if (diff_reg >= MOD_WORD) begin
                        rem_reg <= IDX_BITS'(diff_reg - MOD_WORD);
                    end else begin
                        rem_reg <= IDX_BITS'(diff_reg);
                    end
                    state_reg <= S_READ;
                end

                S_READ: begin
                    // Row read is in flight; data arrives next cycle
                    state_reg <= S_CHECK;
                end

                S_CHECK: begin
                    if (!probe_bit) begin
                        all_set_reg <= 1'b0;
                    end
                    if (pidx_reg == probe_last) begin
                        for (int i = 0; i < MAX_HASHES; i++) begin
                            hash_reg[i] <= '0;
                            mult_reg[i] <= MULT_START;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        state_reg <= S_PSTART;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_op_reg      <= func_reg;
                        m_present_reg <= (func_reg == FUNC_QUERY) && all_set_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                S_CLEAR: begin
                    if (clr_addr_reg == ROW_LAST) begin
                        if (clr_report_reg) begin
                            all_set_reg <= 1'b0;
                            state_reg   <= S_DONE;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
